// ===== rtl/id3tp_pkg.sv =====
// shared types and constants for the id3v2 text frame parser
package id3tp_pkg;

   localparam int TEXT_CAPACITY = 128;
   localparam logic [31:0] POS_LIMIT = 32'(TEXT_CAPACITY - 1);

   localparam logic [7:0] MAGIC_BYTES [3] = '{8'h49, 8'h44, 8'h33};

   localparam int KIND_COUNT = 6;
   localparam logic [31:0] KNOWN_IDS [KIND_COUNT] = '{
      32'h54495432,
      32'h54504531,
      32'h54414C42,
      32'h54594552,
      32'h54434F4E,
      32'h434F4D4D
   };

   localparam logic [2:0] KIND_TITLE   = 3'd0;
   localparam logic [2:0] KIND_COMMENT = 3'd5;
   localparam logic [2:0] KIND_NONE    = 3'd6;

   localparam logic [1:0] STATUS_TEXT  = 2'd0;
   localparam logic [1:0] STATUS_NOTAG = 2'd1;
   localparam logic [1:0] STATUS_DONE  = 2'd2;

   localparam logic [3:0] HDR_LAST   = 4'd9;
   localparam logic [3:0] FRM_LAST   = 4'd9;
   localparam logic [3:0] FRM_FLAGS0 = 4'd8;
   localparam logic [31:0] FRM_HDR_BYTES = 32'd10;
   localparam logic [31:0] COMM_SKIP = 32'd4;
   localparam logic [31:0] TEXT_SKIP = 32'd1;

   typedef enum logic [4:0] {
      PH_HEADER  = 5'b00001,
      PH_FRAME   = 5'b00010,
      PH_PAYLOAD = 5'b00100,
      PH_DONE    = 5'b01000,
      PH_NOTAG   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       byte_valid;
      logic [2:0] field_kind;
      logic       field_end;
      logic [1:0] status;
   } rsp_word_type;

endpackage

// ===== rtl/id3tp_core.sv =====
// parser state and next-state logic, one file byte per accepted word
module id3tp_core
   import id3tp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  logic [7:0]   data_byte,
   input  logic         file_start,
   output logic         res_valid,
   output rsp_word_type res_word
);

   phase_type   phase_ff, phase_in, phase_e;
   logic [3:0]  count_ff, count_in, count_e;
   logic        magic_ff, magic_in, magic_e;
   logic [27:0] tag_len_ff, tag_len_in, tag_len_e;
   logic [31:0] consumed_ff, consumed_in, consumed_e;
   logic [31:0] name_ff, name_in, name_e;
   logic [31:0] flen_ff, flen_in, flen_e;
   logic [31:0] pos_ff, pos_in, pos_e;
   logic        stopped_ff, stopped_in, stopped_e;
   logic [2:0]  kind_ff, kind_in, kind_e;

   logic        magic_ok;
   logic        known;
   logic        last;
   logic        shown;
   logic        finished;
   logic [31:0] skip;
   logic [31:0] pos_next;

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   always_comb begin
      if (file_start) begin
         phase_e    = PH_HEADER;
         count_e    = 4'd0;
         magic_e    = 1'b0;
         tag_len_e  = 28'd0;
         consumed_e = 32'd0;
         name_e     = 32'd0;
         flen_e     = 32'd0;
         pos_e      = 32'd0;
         stopped_e  = 1'b0;
         kind_e     = KIND_TITLE;
      end else begin
         phase_e    = phase_ff;
         count_e    = count_ff;
         magic_e    = magic_ff;
         tag_len_e  = tag_len_ff;
         consumed_e = consumed_ff;
         name_e     = name_ff;
         flen_e     = flen_ff;
         pos_e      = pos_ff;
         stopped_e  = stopped_ff;
         kind_e     = kind_ff;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      magic_in    = magic_ff;
      tag_len_in  = tag_len_ff;
      consumed_in = consumed_ff;
      name_in     = name_ff;
      flen_in     = flen_ff;
      pos_in      = pos_ff;
      stopped_in  = stopped_ff;
      kind_in     = kind_ff;
      res_valid   = 1'b0;
      res_word    = '0;
      magic_ok    = 1'b0;
      known       = (kind_e != KIND_NONE);
      skip        = (kind_e == KIND_COMMENT) ? COMM_SKIP : TEXT_SKIP;
      pos_next    = pos_e + 32'd1;
      last        = (pos_next == flen_e);
      shown       = 1'b0;
      finished    = 1'b0;
      if (take) begin
         phase_in    = phase_e;
         count_in    = count_e;
         magic_in    = magic_e;
         tag_len_in  = tag_len_e;
         consumed_in = consumed_e;
         name_in     = name_e;
         flen_in     = flen_e;
         pos_in      = pos_e;
         stopped_in  = stopped_e;
         kind_in     = kind_e;
         case (phase_e)
            PH_HEADER: begin
               if (count_e < 4'd3) begin
                  magic_ok = (data_byte == MAGIC_BYTES[count_e[1:0]]);
                  magic_in = (count_e == 4'd0) ? magic_ok : (magic_e && magic_ok);
               end
               if (count_e >= 4'd6) begin
                  tag_len_in = {tag_len_e[20:0], data_byte[6:0]};
               end
               if (count_e == 4'd2 && !magic_in) begin
                  phase_in = PH_NOTAG;
                  res_valid = 1'b1;
                  res_word.status = STATUS_NOTAG;
               end else if (count_e >= HDR_LAST) begin
                  count_in = 4'd0;
                  consumed_in = 32'd0;
                  if (tag_len_in == 28'd0) begin
                     phase_in = PH_DONE;
                     res_valid = 1'b1;
                     res_word.status = STATUS_DONE;
                  end else begin
                     phase_in = PH_FRAME;
                  end
               end else begin
                  count_in = count_e + 4'd1;
               end
            end
            PH_FRAME: begin
               if (count_e == 4'd0 && data_byte == 8'd0) begin
                  phase_in = PH_DONE;
                  res_valid = 1'b1;
                  res_word.status = STATUS_DONE;
               end else begin
                  if (count_e < 4'd4) begin
                     name_in = {name_e[23:0], data_byte};
                  end else if (count_e < 4'd8) begin
                     flen_in = {flen_e[23:0], data_byte};
                  end
                  if (count_e == FRM_FLAGS0) begin
                     consumed_in = add_sat(consumed_e, FRM_HDR_BYTES);
                  end
                  if (count_e >= FRM_LAST) begin
                     kind_in = KIND_NONE;
                     for (int k = 0; k < KIND_COUNT; k++) begin
                        if (name_e == KNOWN_IDS[k]) begin
                           kind_in = 3'(k);
                        end
                     end
                     consumed_in = add_sat(consumed_e, flen_e);
                     count_in = 4'd0;
                     pos_in = 32'd0;
                     stopped_in = 1'b0;
                     if (flen_e == 32'd0) begin
                        if (consumed_e >= {4'd0, tag_len_e}) begin
                           phase_in = PH_DONE;
                           res_valid = 1'b1;
                           res_word.status = STATUS_DONE;
                        end
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end else begin
                     count_in = count_e + 4'd1;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (known && !stopped_e && pos_e >= skip && pos_e < POS_LIMIT) begin
                  if (data_byte == 8'd0) begin
                     stopped_in = 1'b1;
                  end else begin
                     shown = 1'b1;
                  end
               end
               pos_in = pos_next;
               if (last) begin
                  count_in = 4'd0;
                  if (consumed_e >= {4'd0, tag_len_e}) begin
                     phase_in = PH_DONE;
                     finished = 1'b1;
                  end else begin
                     phase_in = PH_FRAME;
                  end
               end
               if (known && (shown || last)) begin
                  res_valid = 1'b1;
                  res_word.text_byte = shown ? data_byte : 8'd0;
                  res_word.byte_valid = shown;
                  res_word.field_kind = kind_e;
                  res_word.field_end = last;
                  res_word.status = finished ? STATUS_DONE : STATUS_TEXT;
               end else if (finished) begin
                  res_valid = 1'b1;
                  res_word.status = STATUS_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         count_ff    <= 4'd0;
         magic_ff    <= 1'b0;
         tag_len_ff  <= 28'd0;
         consumed_ff <= 32'd0;
         name_ff     <= 32'd0;
         flen_ff     <= 32'd0;
         pos_ff      <= 32'd0;
         stopped_ff  <= 1'b0;
         kind_ff     <= KIND_TITLE;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         magic_ff    <= magic_in;
         tag_len_ff  <= tag_len_in;
         consumed_ff <= consumed_in;
         name_ff     <= name_in;
         flen_ff     <= flen_in;
         pos_ff      <= pos_in;
         stopped_ff  <= stopped_in;
         kind_ff     <= kind_in;
      end
   end

endmodule

// ===== rtl/id3tp_rsp_reg.sv =====
// result register between the parser and the result channel
module id3tp_rsp_reg
   import id3tp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         res_valid,
   input  rsp_word_type res_word,
   output logic         can_take,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load && res_valid) begin
         valid_in = 1'b1;
         word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== rtl/id3v2_text_frame_parser_top.sv =====
// top level of the id3v2 text frame parser
// Takes a file one byte per word and reports the text of the title, artist,
// album, year, genre and comment frames of an ID3v2.3 tag, plus one status
// word for a missing tag or the end of the tag. One byte is accepted every
// clock cycle; its result, if it has one, is in the result register in the
// next cycle. The rate is set by the combinational next-state logic of the
// parser; input stalls only while the result register holds a word that
// rsp_ready has not taken. A byte with file_start high restarts the parser.
module id3v2_text_frame_parser_top
   import id3tp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_file_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_byte_valid,
   output logic [2:0] rsp_field_kind,
   output logic       rsp_field_end,
   output logic [1:0] rsp_status
);

   logic         take;
   logic         can_take;
   logic         res_valid;
   rsp_word_type res_word;
   rsp_word_type rsp_word;

   assign req_ready = can_take;
   assign take      = req_valid && can_take;

   id3tp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .res_valid  (res_valid),
      .res_word   (res_word)
   );

   id3tp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .res_valid (res_valid),
      .res_word  (res_word),
      .can_take  (can_take),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_text_byte  = rsp_word.text_byte;
   assign rsp_byte_valid = rsp_word.byte_valid;
   assign rsp_field_kind = rsp_word.field_kind;
   assign rsp_field_end  = rsp_word.field_end;
   assign rsp_status     = rsp_word.status;

endmodule
